/* rtl/core/liwt_pkg.sv */
`default_nettype none
package liwt_pkg;

	localparam int unsigned RegW  = 8;
	localparam int unsigned ModeW = 2;
	localparam int unsigned IdxW  = 2;

	typedef logic [RegW-1:0]  count_t;
	typedef logic [ModeW-1:0] mode_t;
	typedef logic [IdxW-1:0]  reg_idx_t;

	localparam mode_t MODE_IDLE    = 2'd0;
	localparam mode_t MODE_MEASURE = 2'd1;
	localparam mode_t MODE_RUN     = 2'd2;

	localparam reg_idx_t REG_RELOAD_TICKS = 2'd0;
	localparam reg_idx_t REG_FLOOR_TICKS  = 2'd1;
	localparam reg_idx_t REG_ON_TICKS     = 2'd2;

	localparam count_t RELOAD_TICKS_RST = 8'd30;
	localparam count_t FLOOR_TICKS_RST  = 8'd10;
	localparam count_t ON_TICKS_RST     = 8'd1;
	localparam count_t COUNT_MAX        = 8'd255;

	localparam logic OP_TICK   = 1'b0;
	localparam logic OP_SWITCH = 1'b1;

	typedef struct packed {
		logic  wiper_drive;
		mode_t mode_now;
	} result_t;

endpackage
`default_nettype wire

/* rtl/core/learned_interval_wiper_timer.sv */
// Intermittent wiper delay timer that learns its interval.
// Input channel (in_valid/in_ready): each transfer is either a timer tick
// (opcode 0) or a sample of the switch level (opcode 1, switch_engaged).
// Output channel (out_valid/out_ready): exactly one result per input item,
// carrying wiper_drive and mode_now as they stand after that item.
// Configuration: cfg_we writes cfg_data into register cfg_index
// (0 reload period, 1 smallest learned period, 2 drive ticks per cycle;
// index 3 ignored).
// Each result is registered, in the result register or, while a result
// waits, in the skid register. Throughput: one item per cycle while in_ready
// is high; one compare/increment stage lies between state and result registers.
// Stall: a second item is still taken while a result waits; it lands in a
// one-entry skid register, and in_ready drops only while that is full.
// Reset (arst_n low): idle mode, counter at 30, learned period 0, switch
// released, registers at 30/10/1, both result registers empty.
`default_nettype none
module learned_interval_wiper_timer
	import liwt_pkg::*;
(
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         cfg_we,
	input  wire reg_idx_t     cfg_index,
	input  wire count_t       cfg_data,
	input  wire logic         in_valid,
	output logic              in_ready,
	input  wire logic         opcode,
	input  wire logic         switch_engaged,
	output logic              out_valid,
	input  wire logic         out_ready,
	output logic              wiper_drive,
	output mode_t             mode_now
);

	count_t  reload_ticks_q, floor_ticks_q, on_ticks_q;
	mode_t   mode_q, mode_n;
	count_t  tick_q, tick_n;
	count_t  learned_q, learned_n;
	logic    last_switch_q, last_switch_n;
	logic    accept;
	result_t res_n, out_q, skid_q;
	logic    out_v_q, skid_v_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reload_ticks_q <= RELOAD_TICKS_RST;
			floor_ticks_q  <= FLOOR_TICKS_RST;
			on_ticks_q     <= ON_TICKS_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_RELOAD_TICKS: reload_ticks_q <= cfg_data;
				REG_FLOOR_TICKS:  floor_ticks_q  <= cfg_data;
				REG_ON_TICKS:     on_ticks_q     <= cfg_data;
				default: ;
			endcase
		end
	end

	assign in_ready = !skid_v_q;
	assign accept   = in_valid && in_ready;

	always_comb begin
		mode_n        = mode_q;
		tick_n        = tick_q;
		learned_n     = learned_q;
		last_switch_n = last_switch_q;
		if (opcode == OP_TICK) begin
			case (mode_q)
				MODE_MEASURE: begin
					// overflow while measuring aborts to idle
					if (tick_q == COUNT_MAX) begin
						mode_n = MODE_IDLE;
						tick_n = reload_ticks_q;
					end else begin
						tick_n = tick_q + 8'd1;
					end
				end
				MODE_RUN: begin
					if (tick_q == learned_q) tick_n = '0;
					else tick_n = tick_q + 8'd1;
				end
				default: ;
			endcase
		end else if (switch_engaged != last_switch_q) begin
			last_switch_n = switch_engaged;
			if (switch_engaged) begin
				learned_n = (tick_q < floor_ticks_q) ? floor_ticks_q : tick_q;
				tick_n    = '0;
				mode_n    = MODE_RUN;
			end else if (mode_q != MODE_IDLE) begin
				mode_n = MODE_MEASURE;
			end
		end
		res_n.wiper_drive = (mode_n == MODE_RUN) && (tick_n < on_ticks_q);
		res_n.mode_now    = mode_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q        <= MODE_IDLE;
			tick_q        <= RELOAD_TICKS_RST;
			learned_q     <= '0;
			last_switch_q <= 1'b0;
		end else if (accept) begin
			mode_q        <= mode_n;
			tick_q        <= tick_n;
			learned_q     <= learned_n;
			last_switch_q <= last_switch_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (!out_v_q || out_ready) begin
			// output slot frees up: refill from skid first, then new item
			out_v_q  <= skid_v_q || accept;
			skid_v_q <= 1'b0;
		end else if (accept) begin
			skid_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_v_q || out_ready) begin
			if (skid_v_q) out_q <= skid_q;
			else if (accept) out_q <= res_n;
		end else if (accept) begin
			skid_q <= res_n;
		end
	end

	assign out_valid   = out_v_q;
	assign wiper_drive = out_q.wiper_drive;
	assign mode_now    = out_q.mode_now;

`ifndef SYNTHESIS
	a_skid_needs_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_v_q |-> out_v_q)
		else $error("skid entry held without a pending output");

	a_stall_to_skid: assert property (@(posedge clk) disable iff (!arst_n)
		(out_v_q && !out_ready && accept) |=> skid_v_q)
		else $error("item taken under stall not held in skid");

	a_drive_only_run: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && wiper_drive) |-> (mode_now == MODE_RUN))
		else $error("drive high outside running mode");

	a_run_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(mode_q == MODE_RUN) |-> (tick_q <= learned_q))
		else $error("running count beyond learned period");
`endif

endmodule
`default_nettype wire

/* tb/tb_top.sv */
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;
	import liwt_pkg::*;

	localparam int       GAP_MAX      = 11;
	localparam int       SETTLE_TICKS = 4;
	localparam int       CYCLE_LIMIT  = 200000;
	localparam reg_idx_t REG_UNUSED   = 2'd3;

	typedef struct packed {
		logic op;
		logic level;
	} wiper_item_t;

	logic     clk = 1'b0;
	logic     arst_n = 1'b0;
	logic     cfg_we = 1'b0;
	reg_idx_t cfg_index = REG_RELOAD_TICKS;
	count_t   cfg_data = '0;
	logic     in_valid = 1'b0;
	logic     in_ready;
	logic     opcode = OP_TICK;
	logic     switch_engaged = 1'b0;
	logic     out_valid;
	logic     out_ready = 1'b0;
	logic     wiper_drive;
	mode_t    mode_now;

	// timer state as seen by the predictor
	mode_t  tm_mode = MODE_IDLE;
	count_t tm_count = RELOAD_TICKS_RST;
	count_t tm_period = '0;
	logic   tm_switch = 1'b0;
	count_t cfg_default = RELOAD_TICKS_RST;
	count_t cfg_minimum = FLOOR_TICKS_RST;
	count_t cfg_pulse = ON_TICKS_RST;

	wiper_item_t pending_items[$];
	result_t     expected_results[$];
	int          queued_total = 0;
	int          send_gap = 0;
	int          recv_stall = 0;
	int          errors = 0;
	int          cycles = 0;
	bit          quiet = 1'b1;

	learned_interval_wiper_timer dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.opcode        (opcode),
		.switch_engaged(switch_engaged),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.wiper_drive   (wiper_drive),
		.mode_now      (mode_now)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	task automatic report_mismatch(input string msg);
		$display("MISMATCH at %0t: %s", $time, msg);
		errors++;
	endtask

	function automatic result_t predict_wiper(input logic op, input logic level);
		result_t r;
		if (op == OP_TICK) begin
			if (tm_mode == MODE_MEASURE) begin
				// overflow while measuring aborts and reloads
				if (tm_count == COUNT_MAX) begin
					tm_mode  = MODE_IDLE;
					tm_count = cfg_default;
				end else begin
					tm_count = tm_count + 1'b1;
				end
			end else if (tm_mode == MODE_RUN) begin
				if (tm_count == tm_period)
					tm_count = '0;
				else
					tm_count = tm_count + 1'b1;
			end
		end else if (level != tm_switch) begin
			tm_switch = level;
			if (level) begin
				tm_period = (tm_count < cfg_minimum) ? cfg_minimum : tm_count;
				tm_count  = '0;
				tm_mode   = MODE_RUN;
			end else if (tm_mode != MODE_IDLE) begin
				tm_mode = MODE_MEASURE;
			end
		end
		r.wiper_drive = (tm_mode == MODE_RUN) && (tm_count < cfg_pulse);
		r.mode_now    = tm_mode;
		return r;
	endfunction

	// driver: present queued items with random gaps
	always @(posedge clk) begin
		wiper_item_t nxt;
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (!in_valid || in_ready) begin
			if (send_gap > 0) begin
				in_valid <= 1'b0;
				send_gap <= send_gap - 1;
			end else if (pending_items.size() > 0) begin
				nxt = pending_items.pop_front();
				in_valid       <= 1'b1;
				opcode         <= nxt.op;
				switch_engaged <= nxt.level;
				send_gap       <= quiet ? 0 : $urandom_range(0, GAP_MAX);
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// monitor: predict on input transfers, check output transfers, stall out_ready
	always @(posedge clk) begin
		result_t want;
		int      stall;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (expected_results.size() == 0) begin
					report_mismatch($sformatf("result with nothing expected: drive=%0b mode=%0d",
						wiper_drive, mode_now));
				end else begin
					want = expected_results.pop_front();
					if (wiper_drive !== want.wiper_drive)
						report_mismatch($sformatf("wiper_drive got %0b want %0b",
							wiper_drive, want.wiper_drive));
					if (mode_now !== want.mode_now)
						report_mismatch($sformatf("mode_now got %0d want %0d",
							mode_now, want.mode_now));
				end
			end
			if (in_valid && in_ready)
				expected_results.push_back(predict_wiper(opcode, switch_engaged));
			stall = recv_stall;
			if (out_valid && out_ready)
				stall = quiet ? 0 : $urandom_range(0, GAP_MAX);
			if (stall > 0) begin
				out_ready  <= 1'b0;
				recv_stall <= stall - 1;
			end else begin
				out_ready  <= 1'b1;
				recv_stall <= 0;
			end
		end
	end

	function automatic void queue_item(input logic op, input logic level);
		pending_items.push_back('{op, level});
		queued_total++;
	endfunction

	function automatic void queue_ticks(input int n);
		for (int i = 0; i < n; i++)
			queue_item(OP_TICK, 1'($urandom_range(0, 1)));
	endfunction

	task automatic await_idle();
		do @(negedge clk);
		while (pending_items.size() != 0 || in_valid || expected_results.size() != 0);
		repeat (SETTLE_TICKS) @(posedge clk);
	endtask

	task automatic set_register(input reg_idx_t idx, input count_t val);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		case (idx)
			REG_RELOAD_TICKS: cfg_default = val;
			REG_FLOOR_TICKS:  cfg_minimum = val;
			REG_ON_TICKS:     cfg_pulse   = val;
			default: ;
		endcase
	endtask

	task automatic run_phase(input count_t dflt, input count_t minp, input count_t pulse,
		input int n_items, input bit overflow);
		int start;
		int n;
		await_idle();
		set_register(REG_UNUSED, count_t'($urandom_range(0, 255)));
		set_register(REG_RELOAD_TICKS, dflt);
		set_register(REG_FLOOR_TICKS, minp);
		set_register(REG_ON_TICKS, pulse);
		@(posedge clk);
		cfg_we <= 1'b0;
		quiet = ($urandom_range(0, 3) == 0);
		if (overflow) begin
			// run, release, then count all the way past 255 into idle
			queue_item(OP_SWITCH, 1'b1);
			queue_item(OP_SWITCH, 1'b0);
			queue_ticks(256);
			queue_ticks(1);
			queue_item(OP_SWITCH, 1'b0);
			queue_item(OP_SWITCH, 1'b1);
			queue_ticks(3);
		end
		start = queued_total;
		while (queued_total - start < n_items) begin
			if ($urandom_range(0, 99) < 80) begin
				queue_item(OP_SWITCH, 1'b1);
				queue_ticks($urandom_range(0, 30));
				queue_item(OP_SWITCH, 1'b0);
				queue_ticks($urandom_range(0, 20));
			end else begin
				n = $urandom_range(1, 3);
				for (int i = 0; i < n; i++)
					queue_item(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
			end
		end
	endtask

	initial begin
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// reset values: idle tick, unchanged level, engage from idle,
		// release while running, engage below minimum, wrap at the period
		queue_item(OP_TICK, 1'b1);
		queue_item(OP_SWITCH, 1'b0);
		queue_item(OP_SWITCH, 1'b1);
		queue_item(OP_TICK, 1'b0);
		queue_item(OP_TICK, 1'b1);
		queue_item(OP_SWITCH, 1'b1);
		queue_item(OP_SWITCH, 1'b0);
		queue_item(OP_TICK, 1'b0);
		queue_item(OP_SWITCH, 1'b0);
		queue_item(OP_SWITCH, 1'b1);
		queue_ticks(11);
		queue_item(OP_SWITCH, 1'b0);

		run_phase(8'd0, 8'd0, 8'd255, 20, 1'b1);
		run_phase(8'd255, 8'd255, 8'd0, 20, 1'b0);
		run_phase(8'd255, 8'd0, 8'd255, 20, 1'b0);
		for (int p = 0; p < 5; p++)
			run_phase(count_t'($urandom_range(0, 255)), count_t'($urandom_range(0, 24)),
				count_t'($urandom_range(0, 12)), 20, 1'b0);

		await_idle();
		if (errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

/* sim.f */
rtl/core/liwt_pkg.sv
rtl/core/learned_interval_wiper_timer.sv
tb/tb_top.sv
